// ===== hdl/vtpd_pkg.sv =====
// Shared types, constants and helpers for the vertex transform block.
package vtpd_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_REGS    = 8;
    localparam int REG_WIDTH   = 64;
    localparam int IDX_WIDTH   = 3;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH - FRAC_BITS + 3;
    localparam int NUM_WIDTH   = COORD_WIDTH + FRAC_BITS + 1;
    localparam int QUO_WIDTH   = NUM_WIDTH;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam logic [REG_WIDTH-1:0] RESET_R0C01 = 64'h0000_0000_0001_0000;
    localparam logic [REG_WIDTH-1:0] RESET_R1C01 = 64'h0001_0000_0000_0000;
    localparam logic [REG_WIDTH-1:0] RESET_R2C23 = 64'h0000_0000_0001_0000;
    localparam logic [REG_WIDTH-1:0] RESET_R3C23 = 64'h0001_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] in_z;
        logic signed [31:0] in_y;
        logic signed [31:0] in_x;
    } in_item_t;

    typedef struct packed {
        logic        w_zero;
        logic signed [31:0] out_z;
        logic signed [31:0] out_y;
        logic signed [31:0] out_x;
    } out_item_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef coord_t [3:0][3:0] matrix_t;  // [row][col]

    function automatic coord_t sat_sum(input logic signed [SUM_WIDTH-1:0] v);
        if (v > SUM_WIDTH'(COORD_MAX)) begin
            return COORD_MAX;
        end else if (v < SUM_WIDTH'(COORD_MIN)) begin
            return COORD_MIN;
        end
        return v[COORD_WIDTH-1:0];
    endfunction

endpackage

// ===== hdl/vtpd_mat_mul.sv =====
// Matrix multiply stages: products, column sums with saturation.
module vtpd_mat_mul (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     in_valid,
    input  vtpd_pkg::in_item_t       in_item,
    input  vtpd_pkg::matrix_t        mat,
    output logic                     out_valid,
    output vtpd_pkg::coord_t [3:0]   out_col
);

    logic signed [vtpd_pkg::PROD_WIDTH-1:0] prod_reg [3][4];
    vtpd_pkg::coord_t                       trans_reg [4];
    logic                                   p_valid_reg;
    vtpd_pkg::coord_t [3:0]                 col_reg;
    logic                                   c_valid_reg;
    vtpd_pkg::coord_t                       pt [3];

    assign pt[0] = in_item.in_x;
    assign pt[1] = in_item.in_y;
    assign pt[2] = in_item.in_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            p_valid_reg <= in_valid;
            c_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 3; r++) begin
                    prod_reg[r][c] <= vtpd_pkg::PROD_WIDTH'(pt[r]) * 0
                                      + $signed(pt[r]) * $signed(mat[r][c]);
                end
                trans_reg[c] <= mat[3][c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                col_reg[c] <= vtpd_pkg::sat_sum(
                    vtpd_pkg::SUM_WIDTH'(trans_reg[c])
                    + vtpd_pkg::SUM_WIDTH'(prod_reg[0][c] >>> vtpd_pkg::FRAC_BITS)
                    + vtpd_pkg::SUM_WIDTH'(prod_reg[1][c] >>> vtpd_pkg::FRAC_BITS)
                    + vtpd_pkg::SUM_WIDTH'(prod_reg[2][c] >>> vtpd_pkg::FRAC_BITS));
            end
        end
    end

    assign out_valid = c_valid_reg;
    assign out_col   = col_reg;

endmodule

// ===== hdl/vtpd_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, three lanes share w.
module vtpd_divider (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  logic                    in_valid,
    input  vtpd_pkg::coord_t [3:0]  in_col,
    output logic                    out_valid,
    output vtpd_pkg::out_item_t     out_item
);
    localparam int NW = vtpd_pkg::NUM_WIDTH;
    localparam int ST = NW + 1;  // stage 0 = setup, then one per quotient bit

    logic [ST-1:0]                  valid_reg;
    logic [NW-1:0]                  num_reg  [ST][3];
    logic [NW:0]                    rem_reg  [ST][3];
    logic [NW-1:0]                  quo_reg  [ST][3];
    logic [ST-1:0][2:0]             neg_reg;
    logic [NW-1:0]                  den_reg  [ST];
    logic [ST-1:0]                  wz_reg;
    vtpd_pkg::coord_t               raw_reg  [ST][3];
    logic [NW-1:0]                  num_abs [3];
    logic [NW-1:0]                  w_abs;
    vtpd_pkg::out_item_t            res_reg;
    logic                           res_valid_reg;

    always_comb begin
        w_abs = in_col[3][vtpd_pkg::COORD_WIDTH-1] ? NW'(-NW'(signed'(in_col[3])))
                                                    : NW'(in_col[3]);
        for (int k = 0; k < 3; k++) begin
            num_abs[k] = in_col[k][vtpd_pkg::COORD_WIDTH-1]
                ? NW'(-(NW'(signed'(in_col[k])) <<< vtpd_pkg::FRAC_BITS))
                : NW'(in_col[k]) << vtpd_pkg::FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg     <= {valid_reg[ST-2:0], in_valid};
            res_valid_reg <= valid_reg[ST-1];
        end
    end

    always_ff @(posedge aclk) begin
        logic [NW:0] tr;
        if (adv) begin
            den_reg[0] <= w_abs;
            wz_reg[0]  <= (in_col[3] == '0);
            for (int k = 0; k < 3; k++) begin
                num_reg[0][k] <= num_abs[k];
                rem_reg[0][k] <= '0;
                quo_reg[0][k] <= '0;
                neg_reg[0][k] <= in_col[k][vtpd_pkg::COORD_WIDTH-1]
                                 ^ in_col[3][vtpd_pkg::COORD_WIDTH-1];
                raw_reg[0][k] <= in_col[k];
            end
            for (int s = 1; s < ST; s++) begin
                den_reg[s] <= den_reg[s-1];
                wz_reg[s]  <= wz_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                for (int k = 0; k < 3; k++) begin
                    raw_reg[s][k] <= raw_reg[s-1][k];
                    tr = {rem_reg[s-1][k][NW-1:0], num_reg[s-1][k][NW-1]};
                    num_reg[s][k] <= num_reg[s-1][k] << 1;
                    if (tr >= {1'b0, den_reg[s-1]}) begin
                        rem_reg[s][k] <= tr - {1'b0, den_reg[s-1]};
                        quo_reg[s][k] <= {quo_reg[s-1][k][NW-2:0], 1'b1};
                    end else begin
                        rem_reg[s][k] <= tr;
                        quo_reg[s][k] <= {quo_reg[s-1][k][NW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Sign, saturate, and bypass on zero w.
    always_ff @(posedge aclk) begin
        logic [NW-1:0]         q;
        logic signed [NW:0]    sq;
        vtpd_pkg::coord_t      v [3];
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                q  = quo_reg[ST-1][k];
                sq = neg_reg[ST-1][k] ? -$signed({1'b0, q}) : $signed({1'b0, q});
                if (wz_reg[ST-1]) begin
                    v[k] = raw_reg[ST-1][k];
                end else if (sq > (NW+1)'(vtpd_pkg::COORD_MAX)) begin
                    v[k] = vtpd_pkg::COORD_MAX;
                end else if (sq < (NW+1)'(vtpd_pkg::COORD_MIN)) begin
                    v[k] = vtpd_pkg::COORD_MIN;
                end else begin
                    v[k] = sq[vtpd_pkg::COORD_WIDTH-1:0];
                end
            end
            res_reg.out_x  <= v[0];
            res_reg.out_y  <= v[1];
            res_reg.out_z  <= v[2];
            res_reg.w_zero <= wz_reg[ST-1];
        end
    end

    assign out_valid = res_valid_reg;
    assign out_item  = res_reg;

endmodule

// ===== hdl/vertex_transform_perspective_divide_top.sv =====
// Pipeline: product and column-sum stages, the divide stages, then an output register.
// Throughput: one transaction per cycle unless stalled; the whole pipeline is one shift line.
// A stall on m_ready freezes every stage; s_ready is low only while a result waits.
// Reset (aresetn low, synchronous) clears all valid bits and loads the identity matrix.
module vertex_transform_perspective_divide_top (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  vtpd_pkg::in_item_t       s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output vtpd_pkg::out_item_t      m_data,
    input  logic                     cfg_we,
    input  logic [vtpd_pkg::IDX_WIDTH-1:0] cfg_index,
    input  logic [vtpd_pkg::REG_WIDTH-1:0] cfg_data
);

    logic [vtpd_pkg::REG_WIDTH-1:0] regs_reg [vtpd_pkg::NUM_REGS];
    vtpd_pkg::matrix_t              mat;
    logic                           adv;
    logic                           mm_valid;
    vtpd_pkg::coord_t [3:0]         mm_col;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg[0] <= vtpd_pkg::RESET_R0C01;
            regs_reg[1] <= '0;
            regs_reg[2] <= vtpd_pkg::RESET_R1C01;
            regs_reg[3] <= '0;
            regs_reg[4] <= '0;
            regs_reg[5] <= vtpd_pkg::RESET_R2C23;
            regs_reg[6] <= '0;
            regs_reg[7] <= vtpd_pkg::RESET_R3C23;
        end else if (cfg_we) begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            mat[r][0] = regs_reg[2*r][vtpd_pkg::COORD_WIDTH-1:0];
            mat[r][1] = regs_reg[2*r][32 +: vtpd_pkg::COORD_WIDTH];
            mat[r][2] = regs_reg[2*r+1][vtpd_pkg::COORD_WIDTH-1:0];
            mat[r][3] = regs_reg[2*r+1][32 +: vtpd_pkg::COORD_WIDTH];
        end
    end

    // Advance the whole pipeline unless a result waits at the output.
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    vtpd_mat_mul u_mm (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(s_valid), .in_item(s_data), .mat(mat),
        .out_valid(mm_valid), .out_col(mm_col)
    );

    vtpd_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(mm_valid), .in_col(mm_col),
        .out_valid(m_valid), .out_item(m_data)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped during stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data))
        else $error("result changed during stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready out of step with output stall");

endmodule

// ===== bench/tb_vertex_transform_perspective_divide_top.sv =====
// Self-checking bench for the vertex transform and perspective divide block.
module tb_vertex_transform_perspective_divide_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 53;
    localparam int DOG_LIMIT  = 5000;
    localparam int HOLD_OFF   = 250;
    localparam int N_PHASES   = 12;
    localparam int PHASE_LEN  = 150;

    typedef struct {
        int                  phase;
        vtpd_pkg::in_item_t  pt;
        bit                  known;
        vtpd_pkg::out_item_t res;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    vtpd_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    vtpd_pkg::out_item_t m_data;
    logic                cfg_we;
    logic [vtpd_pkg::IDX_WIDTH-1:0] cfg_index;
    logic [vtpd_pkg::REG_WIDTH-1:0] cfg_data;

    logic [vtpd_pkg::REG_WIDTH-1:0] matrix_regs [vtpd_pkg::NUM_REGS];
    vtpd_pkg::out_item_t expected_q [$];
    dir_row_t   dir_tab [$];
    bit         quiet;
    bit         stall_req;
    int         mismatches = 0;
    int         unexpected = 0;
    int         accepted_out = 0;
    int         wzero_seen = 0;
    int         in_count = 0;
    int         idle_cycles;

    always #5 aclk = ~aclk;

    vertex_transform_perspective_divide_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic longint coef(int r, int c);
        logic [vtpd_pkg::REG_WIDTH-1:0] word;
        logic signed [31:0]   half;
        word = matrix_regs[r * 2 + c / 2];
        half = (c % 2) ? word[63:32] : word[31:0];
        return longint'(half);
    endfunction

    function automatic longint clamp(longint v);
        if (v > longint'(vtpd_pkg::COORD_MAX)) return longint'(vtpd_pkg::COORD_MAX);
        if (v < longint'(vtpd_pkg::COORD_MIN)) return longint'(vtpd_pkg::COORD_MIN);
        return v;
    endfunction

    function automatic vtpd_pkg::out_item_t transform_point(vtpd_pkg::in_item_t d);
        longint    p [3];
        longint    col [4];
        longint    acc;
        vtpd_pkg::out_item_t o;
        p[0] = longint'(d.in_x);
        p[1] = longint'(d.in_y);
        p[2] = longint'(d.in_z);
        for (int c = 0; c < 4; c++) begin
            acc = coef(3, c);
            for (int r = 0; r < 3; r++) begin
                acc += (p[r] * coef(r, c)) >>> vtpd_pkg::FRAC_BITS;
            end
            col[c] = clamp(acc);
        end
        o.w_zero = (col[3] == 0);
        if (col[3] != 0) begin
            for (int k = 0; k < 3; k++) begin
                col[k] = clamp((col[k] * (64'sd1 <<< vtpd_pkg::FRAC_BITS)) / col[3]);
            end
        end
        o.out_x = col[0][31:0];
        o.out_y = col[1][31:0];
        o.out_z = col[2][31:0];
        return o;
    endfunction

    // Check each result transaction, then predict on each input transaction;
    // directed rows may carry a typed result.
    always @(posedge aclk) begin
        vtpd_pkg::out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            accepted_out++;
            if (m_data.w_zero) wzero_seen++;
            if (expected_q.size() == 0) begin
                unexpected++;
                $display("unexpected result x=%h y=%h z=%h wz=%b",
                         m_data.out_x, m_data.out_y, m_data.out_z, m_data.w_zero);
            end else begin
                e = expected_q.pop_front();
                if (e.out_x !== m_data.out_x || e.out_y !== m_data.out_y ||
                    e.out_z !== m_data.out_z || e.w_zero !== m_data.w_zero) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp x=%h y=%h z=%h wz=%b got x=%h y=%h z=%h wz=%b",
                                 e.out_x, e.out_y, e.out_z, e.w_zero,
                                 m_data.out_x, m_data.out_y, m_data.out_z, m_data.w_zero);
                    end
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            e = transform_point(s_data);
            if (in_count < dir_tab.size() && dir_tab[in_count].known) begin
                e = dir_tab[in_count].res;
            end
            in_count++;
            expected_q = {expected_q, e};
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= DOG_LIMIT) begin
            $display("tb_vertex_transform_perspective_divide_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        bit stall_taken;
        stall_taken = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_req && !stall_taken) begin
                stall_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 20);
            end
        end
    end

    task automatic send(vtpd_pkg::in_item_t d);
        if (!quiet && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() > 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic write_matrix(logic [vtpd_pkg::REG_WIDTH-1:0] m [vtpd_pkg::NUM_REGS]);
        for (int i = 0; i < vtpd_pkg::NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= vtpd_pkg::IDX_WIDTH'(i);
            cfg_data  <= m[i];
            @(posedge aclk);
            matrix_regs[i] = m[i];
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_coef(int mode);
        case (mode)
            0: return 32'($signed(20'($urandom)));
            1: return $urandom;
            default: begin
                case ($urandom_range(4))
                    0: return 32'h0;
                    1: return vtpd_pkg::COORD_MAX;
                    2: return vtpd_pkg::COORD_MIN;
                    3: return 32'h0001_0000;
                    default: return 32'hFFFF_0000;
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0: return pick_coef(2);
            1, 2, 3: return $urandom;
            default: return 32'($signed(24'($urandom)));
        endcase
    endfunction

    task automatic add_row(int ph, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           bit known, logic wz);
        dir_row_t r;
        r.phase = ph;
        r.pt.in_x = x;
        r.pt.in_y = y;
        r.pt.in_z = z;
        r.known = known;
        r.res.out_x = x;
        r.res.out_y = y;
        r.res.out_z = z;
        r.res.w_zero = wz;
        dir_tab = {dir_tab, r};
    endtask

    initial begin
        logic [vtpd_pkg::REG_WIDTH-1:0] m [vtpd_pkg::NUM_REGS];
        int cur_phase;
        int mode;
        vtpd_pkg::in_item_t pt;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        quiet = 1'b0;
        stall_req = 1'b0;
        matrix_regs = '{vtpd_pkg::RESET_R0C01, 64'h0, vtpd_pkg::RESET_R1C01, 64'h0,
                        64'h0, vtpd_pkg::RESET_R2C23, 64'h0, vtpd_pkg::RESET_R3C23};

        // Identity after reset: the point comes back unchanged.
        add_row(0, 32'h0, 32'h0, 32'h0, 1, 1'b0);
        add_row(0, vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MAX, 1, 1'b0);
        add_row(0, vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MIN, 1, 1'b0);
        add_row(0, vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MIN, 32'h0001_0000, 1, 1'b0);
        add_row(0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 1, 1'b0);
        add_row(0, 32'h0000_0001, 32'hFFFF_0000, 32'h0123_4567, 1, 1'b0);
        // Column 3 cleared: w is zero, sums pass through undivided.
        add_row(1, 32'h0, 32'h0, 32'h0, 1, 1'b1);
        add_row(1, vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MIN, 32'h5555_5555, 1, 1'b1);
        add_row(1, vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MAX, 32'hAAAA_AAAA, 1, 1'b1);
        add_row(1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001, 1, 1'b1);
        // Perspective matrix, w = z + 1.0: divide, zero w, saturation.
        add_row(2, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 0, 1'b0);
        add_row(2, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 0, 1'b0);
        add_row(2, 32'h0100_0000, 32'h0100_0000, 32'hFFFF_0001, 0, 1'b0);
        add_row(2, vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MAX, 32'h0, 0, 1'b0);
        add_row(2, vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MAX, 0, 1'b0);
        add_row(2, vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MIN, 0, 1'b0);
        add_row(2, 32'hFFFF_8000, 32'h0000_8000, 32'hFFFE_0000, 0, 1'b0);
        add_row(2, 32'h7FFF_0000, 32'h0, 32'hFFFE_FFFF, 0, 1'b0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cur_phase = 0;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].phase != cur_phase) begin
                drain();
                cur_phase = dir_tab[i].phase;
                m = matrix_regs;
                if (cur_phase == 1) begin
                    m[7] = 64'h0;
                end else begin
                    m = '{64'h0000_0000_0002_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
                          64'h0, 64'h0001_0000_0001_0000,
                          64'h0000_0000_0003_0000, 64'h0001_0000_0000_0000};
                end
                write_matrix(m);
            end
            send(dir_tab[i].pt);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            mode = (ph < 3) ? ph + 3 : $urandom_range(5);
            for (int i = 0; i < vtpd_pkg::NUM_REGS; i++) begin
                case (mode)
                    3: m[i] = {vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MAX};
                    4: m[i] = {vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MIN};
                    5: m[i] = 64'h0;
                    default: m[i] = {pick_coef(mode), pick_coef(mode)};
                endcase
            end
            // Now and then clear column 3 so w is zero.
            if ($urandom_range(3) == 0) begin
                m[1][63:32] = 32'h0;
                m[3][63:32] = 32'h0;
                m[5][63:32] = 32'h0;
                m[7][63:32] = 32'h0;
            end
            write_matrix(m);
            quiet = (ph == 5);
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (ph == 2 && n == 40) stall_req = 1'b1;
                pt.in_x = pick_coord();
                pt.in_y = pick_coord();
                pt.in_z = pick_coord();
                send(pt);
            end
        end

        drain();
        $display("covered directed identity, zero-w and perspective rows plus %0d random phases",
                 N_PHASES);
        $display("results checked: %0d, with zero w: %0d", accepted_out, wzero_seen);
        if (mismatches == 0 && unexpected == 0 && expected_q.size() == 0) begin
            $display("tb_vertex_transform_perspective_divide_top: clean");
        end else begin
            $display("tb_vertex_transform_perspective_divide_top: errors");
        end
        $finish;
    end
endmodule
